@@ hdl/sbda_pkg.sv @@
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants of the decimal text converter
// Holds the character codes, the conversion step size, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [6:0] CHAR_NINE  = 7'd57;

    // Binary bits folded into the BCD register per conversion cycle.
    localparam int DD_BITS = 8;

    typedef struct packed {
        logic load;
        logic convert;
        logic emit_sign;
        logic emit_digit;
    } sbda_cmd_t;

    typedef struct packed {
        logic neg;
        logic conv_last;
        logic digit_last;
    } sbda_status_t;

endpackage

@@ hdl/signed_binary_to_decimal_ascii_top.sv @@
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_top: signed integer to decimal ASCII text
// Prints one two's-complement number as its decimal characters.
// ----------------------------------------------------------------------------
// Usage: drive value and raise start while busy is low; the number is taken
// at that clock edge. Only the low VALUE_WIDTH bits of value are used.
// The characters come out most significant first, each on
// char_code for a single cycle with strobe high. A negative number starts
// with a minus sign, zero prints as a single '0', and last_char marks the
// final character. The receiver cannot hold characters off.
// Sequence: after the accepting edge the BCD conversion folds eight bits per
// cycle through the add-3 unit. Then the minus sign is shown when present,
// and the digit scan steps through every BCD position (20 at a width of 64),
// leading zeros being dropped silently. Busy falls with the last character,
// and the next number can be accepted at the edge ending that cycle. Reset
// returns the block to idle with no strobe.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_top
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value,
    output logic [6:0]  char_code,
    output logic        last_char,
    output logic        strobe
);

    sbda_cmd_t    cmd;
    sbda_status_t status;

    sbda_controller u_controller
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sbda_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .char_code (char_code),
        .last_char (last_char),
        .strobe    (strobe)
    );

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |-> !busy)
        else $error("Last character shown while still busy.");

    a_mid_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_char) |-> busy)
        else $error("Inner character shown while idle.");

    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("Accepted beat not followed by a quiet busy cycle.");

endmodule

@@ hdl/sbda_datapath.sv @@
// ----------------------------------------------------------------------------
// sbda_datapath: magnitude, BCD conversion and character output
// Loads the magnitude of the input, converts it to BCD several bits per cycle
// with the shift-and-add-3 method, then shifts the digits out one per cycle,
// dropping leading zeros, into the output register.
// ----------------------------------------------------------------------------
module sbda_datapath
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [63:0]            value,
    input  sbda_cmd_t              cmd,
    output sbda_status_t           status,
    output logic [6:0]             char_code,
    output logic                   last_char,
    output logic                   strobe
);

    localparam int NUM_PASSES = (VALUE_WIDTH + DD_BITS - 1) / DD_BITS;
    localparam int PAD_W      = NUM_PASSES * DD_BITS;
    localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int PASS_CW    = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
    localparam int DIG_CW     = $clog2(NUM_DIGITS);

    logic [VALUE_WIDTH-1:0] raw_value;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   in_neg;

    logic [PAD_W-1:0]   bin_reg, bin_next, bin_work;
    logic [BCD_W-1:0]   bcd_reg, bcd_next, bcd_work;
    logic               neg_reg, neg_next;
    logic [PASS_CW-1:0] pass_cnt_reg, pass_cnt_next;
    logic [DIG_CW-1:0]  dig_cnt_reg, dig_cnt_next;
    logic               started_reg, started_next;
    logic [3:0]         top_digit;
    logic               show_digit;

    logic [6:0]         char_reg, char_next;
    logic               last_reg, last_next;
    logic               strobe_reg, strobe_next;

    assign raw_value = value[VALUE_WIDTH-1:0];
    assign in_neg    = raw_value[VALUE_WIDTH-1];
    assign mag       = in_neg ? (~raw_value + 1'b1) : raw_value;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign show_digit = started_reg || (top_digit != 4'd0) || (dig_cnt_reg == '0);

    always_comb
    begin
        bcd_work = bcd_reg;
        bin_work = bin_reg;
        for (int b = 0; b < DD_BITS; b++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_work[d*4 +: 4] >= 4'd5)
                begin
                    bcd_work[d*4 +: 4] = bcd_work[d*4 +: 4] + 4'd3;
                end
            end
            bcd_work = {bcd_work[BCD_W-2:0], bin_work[PAD_W-1]};
            bin_work = {bin_work[PAD_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        neg_next      = neg_reg;
        pass_cnt_next = pass_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        started_next  = started_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        strobe_next   = 1'b0;
        if (cmd.load)
        begin
            bin_next      = PAD_W'(mag);
            bcd_next      = '0;
            neg_next      = in_neg;
            pass_cnt_next = PASS_CW'(NUM_PASSES - 1);
            dig_cnt_next  = DIG_CW'(NUM_DIGITS - 1);
            started_next  = 1'b0;
        end
        if (cmd.convert)
        begin
            bin_next      = bin_work;
            bcd_next      = bcd_work;
            pass_cnt_next = pass_cnt_reg - 1'b1;
        end
        if (cmd.emit_sign)
        begin
            char_next   = CHAR_MINUS;
            last_next   = 1'b0;
            strobe_next = 1'b1;
        end
        if (cmd.emit_digit)
        begin
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - 1'b1;
            if (show_digit)
            begin
                started_next = 1'b1;
                char_next    = CHAR_ZERO + {3'd0, top_digit};
                last_next    = (dig_cnt_reg == '0);
                strobe_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_cnt_reg <= '0;
            dig_cnt_reg  <= '0;
            started_reg  <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            pass_cnt_reg <= pass_cnt_next;
            dig_cnt_reg  <= dig_cnt_next;
            started_reg  <= started_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg        = neg_reg;
    assign status.conv_last  = (pass_cnt_reg == '0);
    assign status.digit_last = (dig_cnt_reg == '0);

    assign char_code = char_reg;
    assign last_char = last_reg;
    assign strobe    = strobe_reg;

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code == CHAR_MINUS)
                || (char_code >= CHAR_ZERO && char_code <= CHAR_NINE))
        else $error("Character code out of range.");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && char_code == CHAR_MINUS) |-> !last_char)
        else $error("Minus sign marked as last character.");

endmodule

@@ hdl/sbda_controller.sv @@
// ----------------------------------------------------------------------------
// sbda_controller: sequencing of one conversion
// Steps through load, the BCD conversion passes, the optional minus sign and
// the digit output, and reports busy while a number is in progress.
// ----------------------------------------------------------------------------
module sbda_controller
    import sbda_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  sbda_status_t status,
    output sbda_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_CONVERT = 4'b0010,
        ST_SIGN    = 4'b0100,
        ST_DIGITS  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.conv_last)
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                if (status.digit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.load       = (state_reg == ST_IDLE) && start;
    assign cmd.convert    = (state_reg == ST_CONVERT);
    assign cmd.emit_sign  = (state_reg == ST_SIGN);
    assign cmd.emit_digit = (state_reg == ST_DIGITS);
    assign busy           = (state_reg != ST_IDLE);

    a_sign_after_convert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> ($past(state_reg) == ST_CONVERT) && status.neg)
        else $error("Sign state entered out of sequence.");

endmodule
